// ===== rtl/core/ppi_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and the arithmetic sequence program of the interpolator.
// Used by ppi_ctrl, ppi_dp and the top level; depends on nothing.
package ppi_pkg;

  localparam int MAX_POINTS  = 16;
  localparam int IDX_W       = $clog2(MAX_POINTS);
  localparam int CNT_W       = 5;
  localparam int VALUE_WIDTH = 32;
  localparam int X_W         = 32;
  localparam int DIFF_W      = X_W + 1;
  localparam int LIMB_W      = 32;
  localparam int LIMBS       = 4;
  localparam int PROD_W      = LIMB_W * LIMBS;
  localparam int PP_W        = LIMB_W + DIFF_W;
  localparam int NUM_W       = PROD_W + 2;
  localparam int NMAG_W      = NUM_W - 1;
  localparam int DMAG_W      = 3 * X_W + 1;
  localparam int STEP_W      = 8;
  localparam int PC_W        = 5;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 40;

  localparam logic [PC_W-1:0] PC_LINE = 5'd0;
  localparam logic [PC_W-1:0] PC_PARA = 5'd8;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [CNT_W-1:0] COUNT_RESET = 5'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EDGE, ST_DECIDE, ST_ROUTE, ST_SCAN, ST_CLAMP, ST_FETCH,
    ST_CALC, ST_DIV_INIT, ST_DIV, ST_ROUND, ST_SAT, ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_START, OP_E0, OP_E1, OP_E2, OP_E3, OP_DECIDE, OP_SCAN,
    OP_CLAMP, OP_CAP_A, OP_CAP_B, OP_CAP_C, OP_PLOAD, OP_PMUL, OP_NUM_SET,
    OP_NUM_ADD, OP_DEN_SET, OP_DIV_INIT, OP_DIV_STEP, OP_ROUND, OP_SAT,
    OP_ERR, OP_OUT
  } op_t;

  // factor sources over the three fetched points a, b, c and the target t
  typedef enum logic [3:0] {
    FAC_YA, FAC_YB, FAC_YC, FAC_T_XA, FAC_T_XB, FAC_T_XC,
    FAC_DA, FAC_DB, FAC_NDB, FAC_DC, FAC_GAP, FAC_DY
  } fac_t;

  typedef struct packed {
    op_t              op;
    fac_t             fac;
    logic [2:0]       limb;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] addr;
    logic             we;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic             linear;
    logic [IDX_W-1:0] center;
    logic             den_zero;
    logic             out_busy;
  } stat_t;

  typedef struct packed {
    op_t  op;
    fac_t fac;
    logic last;
  } prog_t;

  // Line: den = gap, num = ya*gap + dy*(t-xa).
  // Parabola: Lagrange form over a, b, c with den = da*db*dc.
  function automatic prog_t prog_step(input logic [PC_W-1:0] pc);
    prog_t p;
    case (pc)
      5'd0:    p = '{op: OP_PLOAD,   fac: FAC_GAP,  last: 1'b0};
      5'd1:    p = '{op: OP_DEN_SET, fac: FAC_YA,   last: 1'b0};
      5'd2:    p = '{op: OP_PLOAD,   fac: FAC_YA,   last: 1'b0};
      5'd3:    p = '{op: OP_PMUL,    fac: FAC_GAP,  last: 1'b0};
      5'd4:    p = '{op: OP_NUM_SET, fac: FAC_YA,   last: 1'b0};
      5'd5:    p = '{op: OP_PLOAD,   fac: FAC_DY,   last: 1'b0};
      5'd6:    p = '{op: OP_PMUL,    fac: FAC_T_XA, last: 1'b0};
      5'd7:    p = '{op: OP_NUM_ADD, fac: FAC_YA,   last: 1'b1};
      5'd8:    p = '{op: OP_PLOAD,   fac: FAC_DA,   last: 1'b0};
      5'd9:    p = '{op: OP_PMUL,    fac: FAC_DB,   last: 1'b0};
      5'd10:   p = '{op: OP_PMUL,    fac: FAC_DC,   last: 1'b0};
      5'd11:   p = '{op: OP_DEN_SET, fac: FAC_YA,   last: 1'b0};
      5'd12:   p = '{op: OP_PLOAD,   fac: FAC_YA,   last: 1'b0};
      5'd13:   p = '{op: OP_PMUL,    fac: FAC_T_XB, last: 1'b0};
      5'd14:   p = '{op: OP_PMUL,    fac: FAC_T_XC, last: 1'b0};
      5'd15:   p = '{op: OP_PMUL,    fac: FAC_DC,   last: 1'b0};
      5'd16:   p = '{op: OP_NUM_SET, fac: FAC_YA,   last: 1'b0};
      5'd17:   p = '{op: OP_PLOAD,   fac: FAC_YB,   last: 1'b0};
      5'd18:   p = '{op: OP_PMUL,    fac: FAC_T_XA, last: 1'b0};
      5'd19:   p = '{op: OP_PMUL,    fac: FAC_T_XC, last: 1'b0};
      5'd20:   p = '{op: OP_PMUL,    fac: FAC_NDB,  last: 1'b0};
      5'd21:   p = '{op: OP_NUM_ADD, fac: FAC_YA,   last: 1'b0};
      5'd22:   p = '{op: OP_PLOAD,   fac: FAC_YC,   last: 1'b0};
      5'd23:   p = '{op: OP_PMUL,    fac: FAC_T_XA, last: 1'b0};
      5'd24:   p = '{op: OP_PMUL,    fac: FAC_T_XB, last: 1'b0};
      5'd25:   p = '{op: OP_PMUL,    fac: FAC_DA,   last: 1'b0};
      5'd26:   p = '{op: OP_NUM_ADD, fac: FAC_YA,   last: 1'b1};
      default: p = '{op: OP_NONE,    fac: FAC_YA,   last: 1'b1};
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/core/ppi_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// Standalone; no package needed.
module ppi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write one entry, read one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

// ===== rtl/core/ppi_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the interpolator: sequences table reads, the arithmetic program
// and the divider. Depends on ppi_pkg.
module ppi_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_mode,
  input  logic [ppi_pkg::IDX_W-1:0] in_point_index,
  input  ppi_pkg::stat_t            stat,
  output ppi_pkg::cmd_t             cmd,
  output logic                      in_tready
);
  import ppi_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [PC_W-1:0]   pc_r, pc_nxt;
  prog_t             prog;

  assign prog = prog_step(pc_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pc_nxt    = pc_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_tvalid && in_mode == MODE_QUERY) begin
          state_nxt = ST_EDGE;
        end
      end
      ST_EDGE: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 8'd4) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: state_nxt = ST_ROUTE;
      ST_ROUTE: begin
        cnt_nxt = '0;
        if (stat.linear) begin
          state_nxt = ST_FETCH;
          pc_nxt    = PC_LINE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == {3'b000, stat.n}) begin
          state_nxt = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        cnt_nxt   = '0;
        pc_nxt    = PC_PARA;
        state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        cnt_nxt = cnt_r + 1'b1;
        if ((stat.linear && cnt_r == 8'd2) || cnt_r == 8'd3) begin
          cnt_nxt   = '0;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (prog.op == OP_PMUL && cnt_r != STEP_W'(LIMBS)) begin
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          cnt_nxt = '0;
          if (prog.last) begin
            state_nxt = ST_DIV_INIT;
          end else begin
            pc_nxt = pc_r + 1'b1;
          end
        end
      end
      ST_DIV_INIT: begin
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(NMAG_W - 1)) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: state_nxt = ST_SAT;
      ST_SAT:   state_nxt = ST_DONE;
      ST_DONE: begin
        if (!stat.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    in_tready = 1'b0;
    cmd.op    = OP_NONE;
    cmd.fac   = FAC_YA;
    cmd.limb  = cnt_r[2:0];
    cmd.idx   = cnt_r[IDX_W-1:0] - 1'b1;
    cmd.addr  = '0;
    cmd.we    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.addr  = in_point_index;
        cmd.we    = in_tvalid && in_mode == MODE_LOAD;
        if (in_tvalid && in_mode == MODE_QUERY) begin
          cmd.op = OP_START;
        end
      end
      ST_EDGE: begin
        case (cnt_r)
          8'd0:    cmd.addr = '0;
          8'd1:    cmd.addr = IDX_W'(1);
          8'd2:    cmd.addr = IDX_W'(stat.n - 5'd2);
          default: cmd.addr = IDX_W'(stat.n - 5'd1);
        endcase
        case (cnt_r)
          8'd1:    cmd.op = OP_E0;
          8'd2:    cmd.op = OP_E1;
          8'd3:    cmd.op = OP_E2;
          8'd4:    cmd.op = OP_E3;
          default: cmd.op = OP_NONE;
        endcase
      end
      ST_DECIDE: cmd.op = OP_DECIDE;
      ST_SCAN: begin
        cmd.addr = cnt_r[IDX_W-1:0];
        if (cnt_r != '0) begin
          cmd.op = OP_SCAN;
        end
      end
      ST_CLAMP: cmd.op = OP_CLAMP;
      ST_FETCH: begin
        cmd.addr = stat.center - 1'b1 + cnt_r[IDX_W-1:0];
        case (cnt_r)
          8'd1:    cmd.op = OP_CAP_A;
          8'd2:    cmd.op = OP_CAP_B;
          8'd3:    cmd.op = OP_CAP_C;
          default: cmd.op = OP_NONE;
        endcase
      end
      ST_CALC: begin
        cmd.op  = prog.op;
        cmd.fac = prog.fac;
      end
      ST_DIV_INIT: cmd.op = OP_DIV_INIT;
      ST_DIV:      cmd.op = OP_DIV_STEP;
      ST_ROUND:    cmd.op = OP_ROUND;
      ST_SAT:      cmd.op = stat.den_zero ? OP_ERR : OP_SAT;
      ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.op = OP_OUT;
        end
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pc_r    <= pc_nxt;
    end
  end

endmodule

// ===== rtl/core/ppi_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the interpolator: point tables, edge tests, nearest-point scan,
// shared limb multiplier, restoring divider, output register. Depends on
// ppi_pkg and ppi_ram.
module ppi_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ppi_pkg::cmd_t                   cmd,
  output ppi_pkg::stat_t                  stat,
  input  logic signed [ppi_pkg::X_W-1:0]  x_value,
  input  logic signed [ppi_pkg::X_W-1:0]  y_value,
  input  logic signed [ppi_pkg::X_W-1:0]  target_x,
  input  logic                            cfg_valid,
  input  logic [ppi_pkg::CNT_W-1:0]       cfg_data,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [ppi_pkg::VALUE_WIDTH-1:0] out_value,
  output logic                            out_method,
  output logic [ppi_pkg::IDX_W-1:0]       out_center,
  output logic                            out_sat,
  output logic                            out_err
);
  import ppi_pkg::*;

  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         n_eff;
  logic signed [X_W-1:0]    x_rd, y_rd;
  logic signed [X_W-1:0]    t_r, ea_r, xa_r, xb_r, xc_r, ya_r, yb_r, yc_r;
  logic                     below_r, above_r, method_r;
  logic [IDX_W-1:0]         s_r, near_r;
  logic [DIFF_W-1:0]        best_r;
  logic [PROD_W-1:0]        prod_r, part_r;
  logic                     psign_r;
  logic [PP_W-1:0]          pp_r;
  logic signed [NUM_W-1:0]  num_r;
  logic [DMAG_W-1:0]        den_mag_r, rem_r;
  logic                     den_neg_r, qneg_r;
  logic [NMAG_W-1:0]        q_r;
  logic [VALUE_WIDTH-1:0]   res_value_r;
  logic                     res_sat_r, res_err_r;
  logic                     out_valid_r;

  logic signed [DIFF_W-1:0] t33, x33, ea33, xa33, xb33, xc33;
  logic signed [DIFF_W-1:0] fval, dscan;
  logic [DIFF_W-1:0]        fmag, scan_mag;
  logic                     fneg;
  logic signed [DIFF_W:0]   e_lhs, e_rhs;
  logic                     e_lt;
  logic [LIMB_W-1:0]        limb_val;
  logic [PP_W-1:0]          pp_mul;
  logic [PROD_W-1:0]        pp_ext, pp_shift;
  logic [1:0]               sh_idx;
  logic signed [NUM_W-1:0]  prod_ext, term, nabs;
  logic [DMAG_W:0]          div_sh, twice;
  logic [DMAG_W+1:0]        div_dif;
  logic                     div_ge, round_up;
  logic                     pos_sat, neg_sat;

  // point tables
  ppi_ram #(.WIDTH(X_W), .DEPTH(MAX_POINTS)) u_xram (
    .clk(clk), .we(cmd.we), .addr(cmd.addr), .wdata(x_value), .rdata(x_rd)
  );
  ppi_ram #(.WIDTH(X_W), .DEPTH(MAX_POINTS)) u_yram (
    .clk(clk), .we(cmd.we), .addr(cmd.addr), .wdata(y_value), .rdata(y_rd)
  );

  // clamp the point count to the table
  always_comb begin
    if (count_r < CNT_W'(2)) begin
      n_eff = CNT_W'(2);
    end else if (count_r > CNT_W'(MAX_POINTS)) begin
      n_eff = CNT_W'(MAX_POINTS);
    end else begin
      n_eff = count_r;
    end
  end

  assign t33  = DIFF_W'(t_r);
  assign x33  = DIFF_W'(x_rd);
  assign ea33 = DIFF_W'(ea_r);
  assign xa33 = DIFF_W'(xa_r);
  assign xb33 = DIFF_W'(xb_r);
  assign xc33 = DIFF_W'(xc_r);

  // edge tests: below on E1, above on E3
  always_comb begin
    if (cmd.op == OP_E1) begin
      e_lhs = {t33 - ea33, 1'b0};
    end else begin
      e_lhs = {x33 - t33, 1'b0};
    end
    e_rhs = (DIFF_W + 1)'(x33 - ea33);
    e_lt  = e_lhs < e_rhs;
  end

  // distance for the nearest point scan
  assign dscan    = x33 - t33;
  assign scan_mag = dscan[DIFF_W-1] ? DIFF_W'(-dscan) : DIFF_W'(dscan);

  // factor select
  always_comb begin
    case (cmd.fac)
      FAC_YA:   fval = DIFF_W'(ya_r);
      FAC_YB:   fval = DIFF_W'(yb_r);
      FAC_YC:   fval = DIFF_W'(yc_r);
      FAC_T_XA: fval = t33 - xa33;
      FAC_T_XB: fval = t33 - xb33;
      FAC_T_XC: fval = t33 - xc33;
      FAC_DA:   fval = xa33 - xb33;
      FAC_DB:   fval = xa33 - xc33;
      FAC_NDB:  fval = xc33 - xa33;
      FAC_DC:   fval = xb33 - xc33;
      FAC_GAP:  fval = xb33 - xa33;
      FAC_DY:   fval = DIFF_W'(yb_r) - DIFF_W'(ya_r);
      default:  fval = '0;
    endcase
    fneg = fval[DIFF_W-1];
    fmag = fneg ? DIFF_W'(-fval) : DIFF_W'(fval);
  end

  // one limb of the running product times the factor
  assign limb_val = prod_r[cmd.limb[1:0]*LIMB_W +: LIMB_W];
  assign pp_mul   = PP_W'(limb_val) * PP_W'(fmag);
  assign sh_idx   = cmd.limb[1:0] - 2'd1;
  assign pp_ext   = PROD_W'(pp_r);
  assign pp_shift = pp_ext << (LIMB_W * sh_idx);

  // signed product term for the numerator
  assign prod_ext = $signed(NUM_W'(prod_r));
  assign term     = psign_r ? -prod_ext : prod_ext;
  assign nabs     = num_r[NUM_W-1] ? -num_r : num_r;

  // restoring divide step and rounding test
  assign div_sh   = {rem_r, q_r[NMAG_W-1]};
  assign div_dif  = {1'b0, div_sh} - (DMAG_W + 2)'(den_mag_r);
  assign div_ge   = !div_dif[DMAG_W+1];
  assign twice    = {rem_r, 1'b0};
  assign round_up = twice >= (DMAG_W + 1)'(den_mag_r);

  // saturation of the rounded magnitude
  assign pos_sat = |q_r[NMAG_W-1:VALUE_WIDTH-1];
  assign neg_sat = (|q_r[NMAG_W-1:VALUE_WIDTH]) ||
                   (q_r[VALUE_WIDTH-1] && (|q_r[VALUE_WIDTH-2:0]));

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_START:  t_r <= target_x;
      OP_E0:     ea_r <= x_rd;
      OP_E1:     below_r <= e_lt;
      OP_E2:     ea_r <= x_rd;
      OP_E3:     above_r <= e_lt || n_eff == CNT_W'(2);
      OP_DECIDE: begin
        method_r <= !(above_r || below_r);
        s_r      <= above_r ? IDX_W'(n_eff - 5'd1) : IDX_W'(1);
      end
      OP_SCAN: begin
        if (cmd.idx == '0 || scan_mag < best_r) begin
          near_r <= cmd.idx;
          best_r <= scan_mag;
        end
      end
      OP_CLAMP: begin
        if (near_r == '0) begin
          s_r <= IDX_W'(1);
        end else if ({1'b0, near_r} > n_eff - 5'd2) begin
          s_r <= IDX_W'(n_eff - 5'd2);
        end else begin
          s_r <= near_r;
        end
      end
      OP_CAP_A: begin
        xa_r <= x_rd;
        ya_r <= y_rd;
      end
      OP_CAP_B: begin
        xb_r <= x_rd;
        yb_r <= y_rd;
      end
      OP_CAP_C: begin
        xc_r <= x_rd;
        yc_r <= y_rd;
      end
      OP_PLOAD: begin
        prod_r  <= PROD_W'(fmag);
        psign_r <= fneg;
      end
      OP_PMUL: begin
        if (cmd.limb < 3'(LIMBS)) begin
          pp_r <= pp_mul;
        end
        if (cmd.limb == '0) begin
          part_r <= '0;
        end else if (cmd.limb != 3'(LIMBS)) begin
          part_r <= part_r + pp_shift;
        end else begin
          prod_r  <= part_r + pp_shift;
          psign_r <= psign_r ^ fneg;
        end
      end
      OP_NUM_SET: num_r <= term;
      OP_NUM_ADD: num_r <= num_r + term;
      OP_DEN_SET: begin
        den_mag_r <= prod_r[DMAG_W-1:0];
        den_neg_r <= psign_r;
      end
      OP_DIV_INIT: begin
        q_r    <= nabs[NMAG_W-1:0];
        rem_r  <= '0;
        qneg_r <= num_r[NUM_W-1] ^ den_neg_r;
      end
      OP_DIV_STEP: begin
        rem_r <= div_ge ? div_dif[DMAG_W-1:0] : div_sh[DMAG_W-1:0];
        q_r   <= {q_r[NMAG_W-2:0], div_ge};
      end
      OP_ROUND: q_r <= q_r + NMAG_W'(round_up);
      OP_SAT: begin
        res_err_r <= 1'b0;
        if (qneg_r) begin
          res_sat_r   <= neg_sat;
          res_value_r <= neg_sat ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                                 : -q_r[VALUE_WIDTH-1:0];
        end else begin
          res_sat_r   <= pos_sat;
          res_value_r <= pos_sat ? {1'b0, {(VALUE_WIDTH-1){1'b1}}}
                                 : q_r[VALUE_WIDTH-1:0];
        end
      end
      OP_ERR: begin
        res_value_r <= '0;
        res_sat_r   <= 1'b0;
        res_err_r   <= 1'b1;
      end
      OP_OUT: begin
        out_value  <= res_value_r;
        out_method <= method_r;
        out_center <= s_r;
        out_sat    <= res_sat_r;
        out_err    <= res_err_r;
      end
      default: ;
    endcase
  end

  // point count register and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= COUNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        count_r <= cfg_data;
      end
      if (cmd.op == OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign stat.n        = n_eff;
  assign stat.linear   = !method_r;
  assign stat.center   = s_r;
  assign stat.den_zero = den_mag_r == '0;
  assign stat.out_busy = out_valid_r && !out_ready;

endmodule

// ===== rtl/core/piecewise_parabolic_interpolator.sv =====
`timescale 1ns / 1ps
// Piecewise parabolic interpolator over a 16 point (x, y) table, signed Q16.16.
// Top level joining ppi_ctrl and ppi_dp; depends on ppi_pkg.
//
// Usage: the input stream carries load items (tuser 0) that write one table
// point and query items (tuser 1) that ask for the value at target_x. Each
// query yields one result item; loads yield none. The point_count register is
// to be written on the cfg channel only while the block is idle; the block
// itself does not enforce it (cfg_ready is always 1). Back-to-back loads are
// taken from the idle state. A query's time goes mostly to the 129-step
// restoring divider, one quotient bit a cycle, plus the shared 32x33 limb
// multiplier, one limb at a time, and the serial nearest-point scan. One
// query is worked on at a time; in_tready is high while the block waits for
// work, including while a finished result sits in the output register. When
// the receiver stalls, the controller waits in its done state with a finished
// result until the output register frees. Reset sets point_count to 2 and
// empties the output; the table holds no defined values until written.
module piecewise_parabolic_interpolator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [3:0] point_index, [35:4] x_value, [67:36] y_value, [99:68] target_x
  input  logic [ppi_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] mode
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] value, [35:32] center_index, [36] saturated, [37] divide_error
  output logic [ppi_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] method
  output logic                               out_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ppi_pkg::CNT_W-1:0]          cfg_data
);
  import ppi_pkg::*;

  cmd_t                   cmd;
  stat_t                  stat;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] o_value;
  logic [IDX_W-1:0]       o_center;
  logic                   o_sat, o_err;

  assign cfg_ready = 1'b1;
  assign in_tready = ready;

  ppi_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_mode        (in_tuser),
    .in_point_index (in_tdata[IDX_W-1:0]),
    .stat           (stat),
    .cmd            (cmd),
    .in_tready      (ready)
  );

  ppi_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .x_value    (in_tdata[35:4]),
    .y_value    (in_tdata[67:36]),
    .target_x   (in_tdata[99:68]),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_value  (o_value),
    .out_method (out_tuser),
    .out_center (o_center),
    .out_sat    (o_sat),
    .out_err    (o_err)
  );

  // pack the result item
  assign out_tdata = {2'b00, o_err, o_sat, o_center, o_value};

endmodule

// ===== test/piecewise_parabolic_interpolator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the piecewise parabolic interpolator: loads point tables,
// runs edge-line and parabola queries with random stalls on both streams.
// Depends on ppi_pkg and piecewise_parabolic_interpolator.
module piecewise_parabolic_interpolator_tb;
  import ppi_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 300;
  localparam int MAX_SHOWN      = 10;

  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic        mode;
    logic [3:0]  slot;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] target;
  } interp_item_t;

  typedef struct {
    logic [31:0] value;
    logic        method;
    logic [3:0]  center;
    logic        sat;
    logic        div_err;
  } interp_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  interp_item_t   pending_items[$];
  interp_result_t expected_results[$];
  interp_item_t   next_item;

  // predictor copy of the table and register
  longint x_tab[MAX_POINTS];
  longint y_tab[MAX_POINTS];
  int     pt_count = 2;

  // generator view of the table it has loaded
  longint gen_x[MAX_POINTS];

  int  send_idle = 28;
  int  recv_idle = 52;
  logic in_fire = 1'b0;
  int  mismatches = 0;
  int  quiet_cycles = 0;

  piecewise_parabolic_interpolator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // rounded n/d with ties away from zero, saturated to 32 bits
  function automatic logic [31:0] round_div(input wide_t num, input wide_t den,
                                            output logic sat);
    logic        neg;
    logic [191:0] nm, dm, q, rm;
    neg = (num < 0) != (den < 0);
    nm = (num < 0) ? -num : num;
    dm = (den < 0) ? -den : den;
    q = nm / dm;
    rm = nm % dm;
    if ((rm << 1) >= dm) q = q + 1;
    sat = 1'b0;
    if (neg) begin
      if (q > 192'h8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      return -q[31:0];
    end
    if (q > 192'h7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return q[31:0];
  endfunction

  function automatic interp_result_t interpolate(input longint t);
    interp_result_t r;
    int     n, s, near;
    longint gap, xa, xb, xc, da, db, dc, ea, eb;
    wide_t  num, den;
    logic   below, above, sat;
    n = pt_count;
    if (n < 2) n = 2;
    if (n > MAX_POINTS) n = MAX_POINTS;
    below = 2 * (t - x_tab[0]) < x_tab[1] - x_tab[0];
    above = (n == 2) || (2 * (x_tab[n-1] - t) < x_tab[n-1] - x_tab[n-2]);
    r.value = '0;
    r.sat = 1'b0;
    r.div_err = 1'b0;
    if (above || below) begin
      r.method = 1'b0;
      s = above ? n - 1 : 1;
      gap = x_tab[s] - x_tab[s-1];
      if (gap == 0) begin
        r.div_err = 1'b1;
      end else begin
        num = wide_t'(y_tab[s-1]) * wide_t'(gap)
            + wide_t'(y_tab[s] - y_tab[s-1]) * wide_t'(t - x_tab[s-1]);
        den = wide_t'(gap);
        r.value = round_div(num, den, sat);
        r.sat = sat;
      end
    end else begin
      r.method = 1'b1;
      near = 0;
      for (int i = 1; i < n; i++) begin
        ea = x_tab[i] - t;
        if (ea < 0) ea = -ea;
        eb = x_tab[near] - t;
        if (eb < 0) eb = -eb;
        if (ea < eb) near = i;
      end
      if (near < 1) near = 1;
      if (near > n - 2) near = n - 2;
      s = near;
      xa = x_tab[s-1];
      xb = x_tab[s];
      xc = x_tab[s+1];
      da = xa - xb;
      db = xa - xc;
      dc = xb - xc;
      den = wide_t'(da) * wide_t'(db) * wide_t'(dc);
      if (den == 0) begin
        r.div_err = 1'b1;
      end else begin
        num = wide_t'(y_tab[s-1]) * wide_t'(t - xb) * wide_t'(t - xc) * wide_t'(dc)
            + wide_t'(y_tab[s]) * wide_t'(t - xa) * wide_t'(t - xc) * wide_t'(-db)
            + wide_t'(y_tab[s+1]) * wide_t'(t - xa) * wide_t'(t - xb) * wide_t'(da);
        r.value = round_div(num, den, sat);
        r.sat = sat;
      end
    end
    r.center = s[3:0];
    return r;
  endfunction

  // Drive the input stream and the receiver stall at the falling edge.
  always @(negedge clk) begin
    if (!in_tvalid || in_fire) begin
      if (rst_n && pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
        next_item = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= next_item.mode;
        in_tdata <= {4'd0, next_item.target, next_item.y, next_item.x, next_item.slot};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle);
  end

  // Track accepted items, predict, check results and watch for a hang.
  always @(posedge clk) begin
    interp_result_t exp_r;
    logic [3:0] slot;
    in_fire <= in_tvalid && in_tready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) pt_count = cfg_data;
      if (in_tvalid && in_tready) begin
        if (in_tuser == MODE_LOAD) begin
          slot = in_tdata[3:0];
          x_tab[slot] = longint'($signed(in_tdata[35:4]));
          y_tab[slot] = longint'($signed(in_tdata[67:36]));
        end else begin
          expected_results.push_back(interpolate(longint'($signed(in_tdata[99:68]))));
        end
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("unexpected result %h/%b", out_tdata, out_tuser);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_tdata[31:0] !== exp_r.value || out_tuser !== exp_r.method ||
              out_tdata[35:32] !== exp_r.center || out_tdata[36] !== exp_r.sat ||
              out_tdata[37] !== exp_r.div_err) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display({"result mismatch: exp value %h method %b center %0d sat %b err %b,",
                        " got value %h method %b center %0d sat %b err %b"},
                       exp_r.value, exp_r.method, exp_r.center, exp_r.sat, exp_r.div_err,
                       out_tdata[31:0], out_tuser, out_tdata[35:32], out_tdata[36],
                       out_tdata[37]);
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic add_load(input int slot, input logic [31:0] x, input logic [31:0] y);
    interp_item_t it;
    it = '{mode: MODE_LOAD, slot: slot[3:0], x: x, y: y, target: $urandom};
    pending_items.push_back(it);
    gen_x[slot] = longint'($signed(x));
  endtask

  task automatic add_query(input logic [31:0] t);
    interp_item_t it;
    it = '{mode: MODE_QUERY, slot: 4'($urandom), x: $urandom, y: $urandom, target: t};
    pending_items.push_back(it);
  endtask

  // Load an ascending table with random spacing and occasional repeated abscissas.
  task automatic load_sorted_table();
    longint xv, gmax;
    int sel;
    logic [31:0] yv;
    sel = $urandom_range(9);
    gmax = (sel < 5) ? (longint'(1) << 18) : (sel < 8) ? (longint'(1) << 10)
                     : (longint'(1) << 26);
    xv = -(longint'(1) << 30) + longint'($urandom_range(32'h2000_0000));
    for (int i = 0; i < MAX_POINTS; i++) begin
      if ($urandom_range(3) == 0)
        yv = $urandom;
      else
        yv = 32'($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
      add_load(i, xv[31:0], yv);
      if ($urandom_range(19) != 0) xv += 1 + longint'($urandom_range(32'(gmax)));
    end
  endtask

  task automatic add_random_query();
    longint lo, hi, span, t;
    int n, sel;
    n = (pt_count < 2) ? 2 : (pt_count > MAX_POINTS) ? MAX_POINTS : pt_count;
    sel = $urandom_range(19);
    if (sel < 14) begin
      lo = gen_x[0];
      hi = gen_x[n-1];
      span = (hi > lo) ? hi - lo : 64;
      t = lo - span / 8 + longint'($urandom_range(32'(span + span / 4 > 32'hFFFF_FFFE ?
                                                      32'hFFFF_FFFE : span + span / 4)));
      if (t > 64'sh7FFF_FFFF) t = 64'sh7FFF_FFFF;
      if (t < -64'sh8000_0000) t = -64'sh8000_0000;
      add_query(t[31:0]);
    end else if (sel < 17) begin
      add_query(gen_x[$urandom_range(n - 1)][31:0]);
    end else begin
      add_query($urandom);
    end
  endtask

  task automatic write_count(input logic [CNT_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold until the block has gone quiet with nothing outstanding.
  task automatic drain();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_tvalid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [CNT_W-1:0] counts[9];
    int target_items;
    counts = '{5'd16, 5'd2, 5'd0, 5'd31, 5'd3, 5'd9, 5'd17, 5'd1, 5'd12};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extreme table, saturation, both edges, a repeated abscissa.
    write_count(5'd16);
    add_load(0, 32'h8000_0000, 32'h7FFF_FFFF);
    for (int i = 1; i < MAX_POINTS - 1; i++)
      add_load(i, 32'($signed(-32'sh7000_0000 + i * 32'sh0F00_0000)),
               (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF);
    add_load(15, 32'h7FFF_FFFF, 32'h8000_0000);
    add_query(32'h8000_0000);
    add_query(32'h7FFF_FFFF);
    add_query(32'h0000_0000);
    add_query(32'h0780_0000);
    add_query(32'hFFFF_FFFF);
    add_load(1, 32'h8000_0000, 32'h0001_0000);
    add_query(32'h8000_0000);
    add_load(3, 32'h8000_0000, 32'h0000_0000);
    add_query(32'h9000_0000);
    drain();

    for (int seg = 0; seg < 9; seg++) begin
      send_idle = (seg < 3) ? 28 : (seg < 6) ? 52 : 0;
      recv_idle = (seg < 3) ? 52 : (seg < 6) ? 28 : 0;
      write_count(counts[seg]);
      load_sorted_table();
      target_items = 147;
      while (pending_items.size() < target_items) begin
        case ($urandom_range(9))
          0: add_load($urandom_range(15), $urandom, $urandom);
          1: load_sorted_table();
          default: add_random_query();
        endcase
      end
      drain();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
